### hdl/gbpb_pkg.sv
// ----------------------------------------------------------------------------
// gbpb_pkg
// Shared widths, types and helpers for the gshare predictor with target buffer.
// ----------------------------------------------------------------------------
package gbpb_pkg;

   localparam int SLOT_BITS    = 8;
   localparam int HISTORY_BITS = 8;
   localparam int PC_BITS      = 32;
   localparam int TABLE_SIZE   = 1 << SLOT_BITS;
   localparam int TAG_BITS     = PC_BITS - 2 - SLOT_BITS;
   localparam int MIX_BITS     = (SLOT_BITS > HISTORY_BITS) ? SLOT_BITS : HISTORY_BITS;

   typedef logic [SLOT_BITS-1:0]    index_type;
   typedef logic [HISTORY_BITS-1:0] history_type;
   typedef logic [TAG_BITS-1:0]     tag_type;
   typedef logic [PC_BITS-1:0]      pc_type;
   typedef logic [1:0]              ctr_type;

   localparam ctr_type CTR_MAX   = 2'd3;
   localparam ctr_type CTR_MIN   = 2'd0;
   localparam ctr_type CTR_TAKEN = 2'd2;
   localparam pc_type  PC_STEP   = pc_type'(4);

   // one target buffer entry as read out
   typedef struct packed {
      logic    valid;
      tag_type tag;
      pc_type  target;
   } btb_entry_type;

   function automatic index_type slot_of(input pc_type pc);
      return pc[2 +: SLOT_BITS];
   endfunction

   function automatic tag_type tag_of(input pc_type pc);
      return pc[PC_BITS-1 -: TAG_BITS];
   endfunction

   // gshare hash: history XOR word index, low index bits
   function automatic index_type counter_index(input history_type hist, input index_type slot);
      logic [MIX_BITS-1:0] h;
      logic [MIX_BITS-1:0] s;
      h = MIX_BITS'(hist);
      s = MIX_BITS'(slot);
      return SLOT_BITS'(h ^ s);
   endfunction

endpackage

### hdl/gbpb_if.sv
// ----------------------------------------------------------------------------
// gbpb_req_if / gbpb_rsp_if
// Valid/ready channels carrying resolved branches and prediction reports.
// ----------------------------------------------------------------------------
interface gbpb_req_if;
   logic            valid;
   logic            ready;
   gbpb_pkg::pc_type branch_pc;
   logic            resolved_taken;
   gbpb_pkg::pc_type actual_next_pc;

   modport source (output valid, output branch_pc, output resolved_taken,
                   output actual_next_pc, input ready);
   modport sink   (input valid, input branch_pc, input resolved_taken,
                   input actual_next_pc, output ready);
endinterface

interface gbpb_rsp_if;
   logic            valid;
   logic            ready;
   logic            prediction_correct;
   logic            guess_taken;
   gbpb_pkg::pc_type predicted_next_pc;

   modport source (output valid, output prediction_correct, output guess_taken,
                   output predicted_next_pc, input ready);
   modport sink   (input valid, input prediction_correct, input guess_taken,
                   input predicted_next_pc, output ready);
endinterface

### hdl/gbpb_target_buffer.sv
// ----------------------------------------------------------------------------
// gbpb_target_buffer
// Direct-mapped branch target buffer: tag/target memory with a registered
// read port, one write port and per-entry valid flops cleared by reset.
// ----------------------------------------------------------------------------
module gbpb_target_buffer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  gbpb_pkg::index_type     rd_index,
   output gbpb_pkg::btb_entry_type rd_entry,
   input  logic                    wr_en,
   input  gbpb_pkg::index_type     wr_index,
   input  gbpb_pkg::tag_type       wr_tag,
   input  gbpb_pkg::pc_type        wr_target
);

   localparam int ENTRY_BITS = gbpb_pkg::TAG_BITS + gbpb_pkg::PC_BITS;

   logic [ENTRY_BITS-1:0]          entry_mem [gbpb_pkg::TABLE_SIZE];
   logic [gbpb_pkg::TABLE_SIZE-1:0] valid_ff;
   logic [gbpb_pkg::TABLE_SIZE-1:0] valid_in;
   gbpb_pkg::btb_entry_type         rd_entry_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_index] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // memory: payload only, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_index] <= {wr_tag, wr_target};
      end
      if (rd_en) begin
         rd_entry_ff.valid <= valid_ff[rd_index];
         {rd_entry_ff.tag, rd_entry_ff.target} <= entry_mem[rd_index];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

### hdl/gshare_branch_predictor_btb_unit.sv
// ----------------------------------------------------------------------------
// gshare_branch_predictor_btb_unit
// Gshare direction predictor with a direct-mapped branch target buffer,
// trained by resolved branches.
// ----------------------------------------------------------------------------
// Each item is one resolved branch. The unit looks up the 2-bit counter picked
// by history XOR PC word index and the target buffer entry picked by the word
// index, reports the prediction it would have made and whether it was right,
// then trains the counter, rewrites the buffer entry on a taken branch and
// shifts the outcome into the global history. Each item first reads the counter
// and buffer memories synchronously; the write-back state then computes the
// report and writes back. req ready is low during the write-back state, so the
// next item always reads the updated history, counter and buffer entry and
// there is no same-entry hazard. A new item is not taken before the last one
// has written back; a stalled rsp holds the write-back state. Reset takes
// effect at once: counters and buffer entries carry per-entry valid flops,
// so there is no clearing pass.
// ----------------------------------------------------------------------------
module gshare_branch_predictor_btb_unit (
   input  logic       clock,
   input  logic       reset,
   gbpb_req_if.sink   req_bus,
   gbpb_rsp_if.source rsp_bus
);

   localparam logic ST_IDLE   = 1'b0;   // waiting for an item
   localparam logic ST_UPDATE = 1'b1;   // memory data back, compute and write

   logic state_ff, state_in;

   // held item
   gbpb_pkg::pc_type      item_pc_ff;
   logic                  item_taken_ff;
   gbpb_pkg::pc_type      item_next_ff;
   gbpb_pkg::index_type   item_cidx_ff;
   gbpb_pkg::history_type history_ff, history_in;

   // counter table: memory plus per-entry written flops (unwritten reads 0)
   gbpb_pkg::ctr_type               ctr_mem [gbpb_pkg::TABLE_SIZE];
   logic [gbpb_pkg::TABLE_SIZE-1:0] ctr_written_ff, ctr_written_in;
   gbpb_pkg::ctr_type               ctr_rd_ff;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_correct_ff;
   logic             rsp_taken_ff;
   gbpb_pkg::pc_type rsp_next_ff;

   logic                    req_accept;
   logic                    finish;
   gbpb_pkg::index_type     req_slot;
   gbpb_pkg::index_type     req_cidx;
   gbpb_pkg::btb_entry_type btb_entry;
   logic                    btb_hit;
   logic                    pred_taken;
   gbpb_pkg::pc_type        pred_next;
   logic                    pred_correct;
   gbpb_pkg::ctr_type       ctr_next;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign req_slot      = gbpb_pkg::slot_of(req_bus.branch_pc);
   assign req_cidx      = gbpb_pkg::counter_index(history_ff, req_slot);

   // write back once the result register can take the report
   assign finish = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_bus.ready);

   gbpb_target_buffer u_btb (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_index  (req_slot),
      .rd_entry  (btb_entry),
      .wr_en     (finish && item_taken_ff),
      .wr_index  (gbpb_pkg::slot_of(item_pc_ff)),
      .wr_tag    (gbpb_pkg::tag_of(item_pc_ff)),
      .wr_target (item_next_ff)
   );

   // prediction from the read data
   always_comb begin
      pred_taken = (ctr_rd_ff >= gbpb_pkg::CTR_TAKEN);
      btb_hit    = btb_entry.valid && (btb_entry.tag == gbpb_pkg::tag_of(item_pc_ff));
      pred_next  = btb_hit ? btb_entry.target : (item_pc_ff + gbpb_pkg::PC_STEP);
      if (item_taken_ff) begin
         pred_correct = pred_taken && (item_next_ff == pred_next);
      end else begin
         pred_correct = !pred_taken;
      end
      // saturating training
      ctr_next = ctr_rd_ff;
      if (item_taken_ff) begin
         if (ctr_rd_ff != gbpb_pkg::CTR_MAX) begin
            ctr_next = ctr_rd_ff + 2'd1;
         end
      end else if (ctr_rd_ff != gbpb_pkg::CTR_MIN) begin
         ctr_next = ctr_rd_ff - 2'd1;
      end
   end

   always_comb begin
      state_in       = state_ff;
      history_in     = history_ff;
      ctr_written_in = ctr_written_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (finish) begin
               state_in                     = ST_IDLE;
               history_in                   = gbpb_pkg::history_type'({history_ff,
                                                                       item_taken_ff});
               ctr_written_in[item_cidx_ff] = 1'b1;
               rsp_valid_in                 = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         history_ff     <= '0;
         ctr_written_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         history_ff     <= history_in;
         ctr_written_ff <= ctr_written_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload and memory
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_pc_ff    <= req_bus.branch_pc;
         item_taken_ff <= req_bus.resolved_taken;
         item_next_ff  <= req_bus.actual_next_pc;
         item_cidx_ff  <= req_cidx;
         ctr_rd_ff     <= ctr_written_ff[req_cidx] ? ctr_mem[req_cidx] : gbpb_pkg::CTR_MIN;
      end
      if (finish) begin
         ctr_mem[item_cidx_ff] <= ctr_next;
         rsp_correct_ff        <= pred_correct;
         rsp_taken_ff          <= pred_taken;
         rsp_next_ff           <= pred_next;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.prediction_correct = rsp_correct_ff;
   assign rsp_bus.guess_taken        = rsp_taken_ff;
   assign rsp_bus.predicted_next_pc  = rsp_next_ff;

   // checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_UPDATE) && !req_bus.ready)
      else $error("accepted item did not start a lookup");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("report appeared without a write-back");

   a_history_shift: assert property (@(posedge clock) disable iff (reset)
      finish |=> history_ff[0] == $past(item_taken_ff))
      else $error("history did not take the outcome");

   a_no_lost_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |-> !rsp_valid_ff || rsp_bus.ready)
      else $error("report overwritten before it was taken");

endmodule

### tb/sv/gshare_branch_predictor_btb_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gshare_branch_predictor_btb_unit_tb
// Self-checking bench for the gshare predictor with its branch target buffer.
// A scoreboard class holds its own copy of the history, the counters and the
// buffer, and works out the report for every accepted item. Stimulus is a
// short directed run and then mostly trained branch sites with some noise.
// ----------------------------------------------------------------------------
module gshare_branch_predictor_btb_unit_tb;

   localparam int RANDOM_ITEMS    = 530;
   localparam int SITE_COUNT      = 16;
   localparam int RSP_HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int IDLE_LIMIT      = 5000;  // watchdog, cycles with no handshake
   localparam int TAIL_CYCLES     = 20;    // idle tail after the final drain
   localparam int HOLD_AT_ITEM    = 150;
   localparam int PAUSE_AT_ITEM   = 350;

   // one prediction report, as the result channel carries it
   typedef struct packed {
      logic             correct;
      logic             taken;
      gbpb_pkg::pc_type next_pc;
   } branch_report_type;

   // -------------------------------------------------------------------------
   // Scoreboard: mirror of the predictor state plus the queue of reports
   // still owed by the block.
   // -------------------------------------------------------------------------
   class branch_scoreboard;
      gbpb_pkg::history_type history;
      gbpb_pkg::ctr_type     counters     [gbpb_pkg::TABLE_SIZE];
      bit                    entry_valid  [gbpb_pkg::TABLE_SIZE];
      gbpb_pkg::tag_type     entry_tag    [gbpb_pkg::TABLE_SIZE];
      gbpb_pkg::pc_type      entry_target [gbpb_pkg::TABLE_SIZE];
      branch_report_type     expected_reports [$];
      int unsigned           failures;
      int unsigned           reports_checked;
      int unsigned           target_hits;
      int unsigned           taken_predictions;
      int unsigned           right_predictions;

      function new();
         history = '0;
         foreach (counters[i]) begin
            counters[i]    = gbpb_pkg::CTR_MIN;
            entry_valid[i] = 1'b0;
         end
      endfunction

      // an accepted resolved branch: work out its report, then train
      function void note_branch(gbpb_pkg::pc_type pc, logic taken,
                                gbpb_pkg::pc_type next_pc);
         gbpb_pkg::index_type slot;
         gbpb_pkg::index_type cidx;
         gbpb_pkg::tag_type   tag;
         gbpb_pkg::ctr_type   ctr;
         logic [31:0]         mix;
         logic                hit;
         branch_report_type   rep;
         slot = pc[2 +: gbpb_pkg::SLOT_BITS];
         tag  = pc[gbpb_pkg::PC_BITS-1 -: gbpb_pkg::TAG_BITS];
         mix  = 32'(history) ^ 32'(slot);
         cidx = mix[gbpb_pkg::SLOT_BITS-1:0];   // low index bits of history XOR slot
         ctr  = counters[cidx];
         hit  = entry_valid[slot] && (entry_tag[slot] == tag);
         if (hit)
            target_hits++;
         rep.taken   = (ctr >= gbpb_pkg::CTR_TAKEN);
         rep.next_pc = hit ? entry_target[slot] : pc + gbpb_pkg::PC_STEP;  // wraps at the top
         rep.correct = taken ? (rep.taken && (next_pc == rep.next_pc)) : !rep.taken;
         expected_reports.push_back(rep);
         if (taken) begin
            // overwritten on every taken branch, hit or miss
            entry_valid[slot]  = 1'b1;
            entry_tag[slot]    = tag;
            entry_target[slot] = next_pc;
            if (ctr != gbpb_pkg::CTR_MAX)
               counters[cidx] = ctr + 2'd1;
         end else begin
            if (ctr != gbpb_pkg::CTR_MIN)
               counters[cidx] = ctr - 2'd1;
         end
         history = gbpb_pkg::history_type'({history, taken});
      endfunction

      function void check_report(logic correct, logic taken, gbpb_pkg::pc_type next_pc);
         branch_report_type exp_rep;
         if (expected_reports.size() == 0) begin
            $error("report with nothing outstanding (correct %0b taken %0b next %h)",
                   correct, taken, next_pc);
            failures++;
            return;
         end
         exp_rep = expected_reports.pop_front();
         reports_checked++;
         if (exp_rep.taken)
            taken_predictions++;
         if (exp_rep.correct)
            right_predictions++;
         if (correct !== exp_rep.correct) begin
            $error("prediction_correct: expected %0b, got %0b", exp_rep.correct, correct);
            failures++;
         end
         if (taken !== exp_rep.taken) begin
            $error("guess_taken: expected %0b, got %0b", exp_rep.taken, taken);
            failures++;
         end
         if (next_pc !== exp_rep.next_pc) begin
            $error("predicted_next_pc: expected %h, got %h", exp_rep.next_pc, next_pc);
            failures++;
         end
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block itself
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   gbpb_req_if req_if ();
   gbpb_rsp_if rsp_if ();

   gshare_branch_predictor_btb_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   branch_scoreboard sb = new();

   int unsigned items_accepted;
   int unsigned idle_cycles;
   int          burst_left;      // items left in the current sender burst
   bit          hold_rsp;        // asks the receiver for its long hold-off

   // branch sites used by the trained part of the random run
   gbpb_pkg::pc_type site_pc     [SITE_COUNT];
   gbpb_pkg::pc_type site_target [SITE_COUNT];
   int               site_bias   [SITE_COUNT];  // chance of taken, in percent

   // -------------------------------------------------------------------------
   // Monitor: both channels sampled at the edge. Input first, so a report
   // that could come out in the same cycle already has its expectation.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            sb.note_branch(req_if.branch_pc, req_if.resolved_taken, req_if.actual_next_pc);
            items_accepted++;
         end
         if (rsp_if.valid && rsp_if.ready)
            sb.check_report(rsp_if.prediction_correct, rsp_if.guess_taken,
                            rsp_if.predicted_next_pc);
      end
   end

   // Watchdog: any handshake restarts the count, so the limit covers the
   // longest stall rather than the whole run.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: stretches of always-ready, light, heavy and very heavy stalls,
   // plus one long hold-off on request so the block backs up into its input.
   // -------------------------------------------------------------------------
   initial begin : receiver
      int mode;
      int left;
      rsp_if.ready = 1'b0;
      left = 0;
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            left = 0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(1, 40);
         end
         left--;
         case (mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_if.ready <= ($urandom_range(0, 1) != 0);
            default: rsp_if.ready <= ($urandom_range(0, 4) == 0);
         endcase
         @(posedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------

   // Offer one branch and return at the edge that accepts it. Between bursts
   // valid drops for a random gap; a gap of zero keeps it high throughout.
   task automatic offer_branch(input gbpb_pkg::pc_type pc, input logic taken,
                               input gbpb_pkg::pc_type next_pc);
      int gap;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_if.valid          <= 1'b1;
      req_if.branch_pc      <= pc;
      req_if.resolved_taken <= taken;
      req_if.actual_next_pc <= next_pc;
      do
         @(posedge clock);
      while (!req_if.ready);
   endtask

   // Stop offering and wait until every owed report has come back. At least
   // one edge passes, so valid is never lowered and raised in one step.
   task automatic drain_reports();
      req_if.valid <= 1'b0;
      burst_left = 0;
      do
         @(posedge clock);
      while (sb.pending() != 0);
   endtask

   // fresh branch site; an odd site may alias the slot of its neighbour with a
   // different tag, so tag misses on a valid entry are frequent
   task automatic renew_site(input int s);
      if ((s % 2 == 1) && ($urandom_range(0, 1) == 1))
         site_pc[s] = site_pc[s-1] ^ (gbpb_pkg::pc_type'($urandom_range(1, 1023))
                                      << (2 + gbpb_pkg::SLOT_BITS));
      else
         site_pc[s] = $urandom;
      site_target[s] = $urandom;
      case ($urandom_range(0, 3))
         0:       site_bias[s] = 95;
         1:       site_bias[s] = 5;
         2:       site_bias[s] = 50;
         default: site_bias[s] = 80;
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int               s;
      int               directed_items;
      gbpb_pkg::pc_type pc;
      gbpb_pkg::pc_type next_pc;
      logic             taken;

      req_if.valid          = 1'b0;
      req_if.branch_pc      = '0;
      req_if.resolved_taken = 1'b0;
      req_if.actual_next_pc = '0;
      hold_rsp              = 1'b0;
      burst_left            = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // counter at its floor stays there on a not-taken branch
      offer_branch(32'h0000_0000, 1'b0, 32'h0000_0004);
      // miss at the top of memory: PC plus four wraps to zero
      offer_branch(32'hFFFF_FFFC, 1'b1, 32'h0000_0000);
      // same entry, odd low bits: tag hit on the entry just written
      offer_branch(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
      offer_branch(32'hFFFF_FFFC, 1'b0, 32'h0000_0000);
      // a steady taken loop: history fills with ones and the counter it
      // settles on saturates at the top
      repeat (12) offer_branch(32'h0000_0100, 1'b1, 32'h0000_0200);
      // same slot, other tag: a valid entry that must not hit
      offer_branch(32'h0000_0500, 1'b1, 32'h1234_5678);
      offer_branch(32'h0000_0100, 1'b1, 32'h0000_0300);
      // hit with a stale target: direction right, target wrong
      offer_branch(32'h0000_0100, 1'b1, 32'h0000_0200);
      // not taken leaves the entry alone; the next lookup still hits
      offer_branch(32'h0000_0100, 1'b0, 32'h0000_0104);
      offer_branch(32'h0000_0100, 1'b1, 32'h0000_0200);
      offer_branch(32'h8000_0000, 1'b1, 32'hFFFF_FFFF);
      directed_items = items_accepted;

      // ---- random part ----
      for (int i = 0; i < SITE_COUNT; i++)
         renew_site(i);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == HOLD_AT_ITEM) begin
            // receiver holds off while the sender keeps offering
            hold_rsp   = 1'b1;
            burst_left = 60;
         end
         if (n == PAUSE_AT_ITEM)
            drain_reports();
         if (n % 50 == 49)
            renew_site($urandom_range(0, SITE_COUNT - 1));

         if ($urandom_range(0, 99) < 80) begin
            // trained site: mostly its usual target, now and then a new one
            s     = $urandom_range(0, SITE_COUNT - 1);
            pc    = site_pc[s];
            taken = ($urandom_range(0, 99) < site_bias[s]);
            if (!taken)
               next_pc = pc + gbpb_pkg::PC_STEP;
            else if ($urandom_range(0, 19) == 0)
               next_pc = $urandom;
            else
               next_pc = site_target[s];
         end else begin
            // noise: any PC, any outcome, any next address
            pc      = $urandom;
            taken   = 1'($urandom_range(0, 1));
            next_pc = $urandom;
         end
         offer_branch(pc, taken, next_pc);
      end

      // ---- wind down ----
      drain_reports();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d branches (%0d directed) with bursty input, a %0d-cycle result hold-off",
               items_accepted, directed_items, RSP_HOLD_CYCLES);
      $display("and a full drain; %0d reports checked: %0d buffer hits, %0d taken, %0d right.",
               sb.reports_checked, sb.target_hits, sb.taken_predictions, sb.right_predictions);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### sim.f
hdl/gbpb_pkg.sv
hdl/gbpb_if.sv
hdl/gbpb_target_buffer.sv
hdl/gshare_branch_predictor_btb_unit.sv
tb/sv/gshare_branch_predictor_btb_unit_tb.sv
